// ===== rtl/sct_pkg.sv =====
package sct_pkg;

    // Default coordinate width, signed Q16.8
    localparam int COORD_WIDTH_DEF = 24;

    // Number of coordinate fields in one input transfer
    localparam int NUM_COORDS = 10;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Result codes
    typedef enum logic [1:0] {
        VERDICT_CROSS    = 2'd0,
        VERDICT_APART    = 2'd1,
        VERDICT_PARALLEL = 2'd2,
        VERDICT_OUTSIDE  = 2'd3
    } verdict_t;

    // Per-item flags that travel down the back pipeline
    typedef struct packed {
        logic rej;    // extents do not overlap
        logic vert;   // either segment vertical
        logic aflat;  // segment a horizontal
        logic bflat;  // segment b horizontal
    } flag_t;

    // Determinant status, known after the determinant stage
    typedef struct packed {
        logic zero;
        logic neg;
    } det_stat_t;

endpackage

// ===== rtl/sct_fifo.sv =====
module sct_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             nonempty,
    output logic [WIDTH-1:0] pop_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

// ===== rtl/sct_front.sv =====
module sct_front #(
    parameter int W = 24
) (
    input  logic [10*W-1:0]  in_data,
    output logic [8*W+4:0]   item
);
    import sct_pkg::*;

    localparam int EW = W + 1;

    logic signed [W-1:0]  ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, sx, sy;
    logic signed [W-1:0]  oax1, oay1, oax2, oay2, obx1, oby1, obx2, oby2;
    logic signed [EW-1:0] sbx1, sby1, sbx2, sby2;
    logic signed [EW-1:0] eax1, eax2, amin, amax, bmin, bmax;
    logic                 rej;

    // Split fields
    assign ax1 = in_data[0*W +: W];
    assign ay1 = in_data[1*W +: W];
    assign ax2 = in_data[2*W +: W];
    assign ay2 = in_data[3*W +: W];
    assign bx1 = in_data[4*W +: W];
    assign by1 = in_data[5*W +: W];
    assign bx2 = in_data[6*W +: W];
    assign by2 = in_data[7*W +: W];
    assign sx  = in_data[8*W +: W];
    assign sy  = in_data[9*W +: W];

    // Order endpoints by x, shift segment b and check extents
    always_comb begin
        if (ax2 < ax1) begin
            oax1 = ax2; oay1 = ay2; oax2 = ax1; oay2 = ay1;
        end else begin
            oax1 = ax1; oay1 = ay1; oax2 = ax2; oay2 = ay2;
        end
        if (bx2 < bx1) begin
            obx1 = bx2; oby1 = by2; obx2 = bx1; oby2 = by1;
        end else begin
            obx1 = bx1; oby1 = by1; obx2 = bx2; oby2 = by2;
        end
        sbx1 = EW'(obx1) + EW'(sx);
        sbx2 = EW'(obx2) + EW'(sx);
        sby1 = EW'(oby1) + EW'(sy);
        sby2 = EW'(oby2) + EW'(sy);
        eax1 = EW'(oax1);
        eax2 = EW'(oax2);
        amin = (oay1 < oay2) ? EW'(oay1) : EW'(oay2);
        amax = (oay1 < oay2) ? EW'(oay2) : EW'(oay1);
        bmin = (sby1 < sby2) ? sby1 : sby2;
        bmax = (sby1 < sby2) ? sby2 : sby1;
        rej  = (eax2 < sbx1) || (sbx2 < eax1) || (bmax < amin) || (amax < bmin);
    end

    assign item = {rej, sby2, sbx2, sby1, sbx1, oay2, oax2, oay1, oax1};

endmodule

// ===== rtl/sct_mul.sv =====
module sct_mul #(
    parameter int AW = 53,
    parameter int BW = 26
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] prod
);
    localparam int LW = AW / 2;
    localparam int HW = AW - LW;
    localparam int PW = AW + BW;

    logic signed [LW:0]        a_lo;
    logic signed [HW-1:0]      a_hi;
    logic signed [LW+BW:0]     plo_reg;
    logic signed [HW+BW-1:0]   phi_reg;
    logic signed [PW-1:0]      prod_reg;

    assign a_lo = $signed({1'b0, a[LW-1:0]});
    assign a_hi = a[AW-1:LW];

    // Partial products, then combine
    always_ff @(posedge aclk) begin
        if (en) begin
            plo_reg  <= a_lo * b;
            phi_reg  <= a_hi * b;
            prod_reg <= (PW'(phi_reg) <<< LW) + PW'(plo_reg);
        end
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/sct_back.sv =====
module sct_back #(
    parameter int W = 24
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    input  logic [8*W+4:0] in_item,
    output logic           in_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           out_crosses,
    output logic [1:0]     out_verdict
);
    import sct_pkg::*;

    localparam int EW = W + 1;
    localparam int DW = W + 2;
    localparam int PW = 2 * DW;
    localparam int KW = PW + 1;
    localparam int RW = KW + DW;
    localparam int NW = RW + 1;
    localparam int BO = 4 * W;
    localparam int NMUL = 10;

    logic en;

    // Item fields
    logic signed [W-1:0]  iax1, iay1, iax2, iay2;
    logic signed [EW-1:0] ibx1, iby1, ibx2, iby2;
    logic                 irej;

    // Stage 1: differences, bounds, flags
    logic                 v1_reg;
    logic signed [DW-1:0] a_reg, b_reg, a2_reg, b2_reg;
    logic signed [DW-1:0] ax1_reg, ay1_reg, ax2_reg, ay2_reg;
    logic signed [DW-1:0] bx1_reg, by1_reg, bx2_reg, by2_reg;
    logic signed [DW-1:0] lo_reg, hi_reg, amin_reg, amax_reg, bmin_reg, bmax_reg;
    flag_t                f1_reg;
    logic signed [DW-1:0] a_next, b_next, a2_next, b2_next;

    // Stage 2: first products
    logic                 v2_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    logic signed [DW-1:0] a_2_reg, b_2_reg, a2_2_reg, b2_2_reg;
    logic signed [DW-1:0] bnd2_reg [6];
    flag_t                f2_reg;

    // Stage 3: determinant and line constants
    logic                 v3_reg;
    logic signed [KW-1:0] det_reg, c_reg, c2_reg;
    logic signed [DW-1:0] a_3_reg, b_3_reg, a2_3_reg, b2_3_reg;
    logic signed [DW-1:0] bnd3_reg [6];
    flag_t                f3_reg;

    // Stages 4 and 5: wide products
    logic                 v4_reg, v5_reg;
    flag_t                f4_reg, f5_reg;
    det_stat_t            d4_reg, d5_reg;
    logic signed [KW-1:0] mul_a [NMUL];
    logic signed [DW-1:0] mul_b [NMUL];
    logic signed [RW-1:0] mul_p [NMUL];

    // Stage 6: numerators
    logic                 v6_reg;
    flag_t                f6_reg;
    det_stat_t            d6_reg;
    logic signed [NW-1:0] nx_reg, ny_reg;
    logic signed [NW-1:0] bp_reg [6];

    // Stage 7: result register
    logic                 v7_reg;
    verdict_t             verdict_reg;
    verdict_t             verdict_next;
    logic                 in_x, in_ya, in_yb;

    assign en     = !v7_reg || out_ready;
    assign in_pop = en;

    assign iax1 = in_item[0*W +: W];
    assign iay1 = in_item[1*W +: W];
    assign iax2 = in_item[2*W +: W];
    assign iay2 = in_item[3*W +: W];
    assign ibx1 = in_item[BO + 0*EW +: EW];
    assign iby1 = in_item[BO + 1*EW +: EW];
    assign ibx2 = in_item[BO + 2*EW +: EW];
    assign iby2 = in_item[BO + 3*EW +: EW];
    assign irej = in_item[BO + 4*EW];

    assign a_next  = DW'(iay2) - DW'(iay1);
    assign b_next  = DW'(iax1) - DW'(iax2);
    assign a2_next = DW'(iby2) - DW'(iby1);
    assign b2_next = DW'(ibx1) - DW'(ibx2);

    // Valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
            v5_reg <= 1'b0; v6_reg <= 1'b0; v7_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // Stage 1
    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            a2_reg   <= a2_next;
            b2_reg   <= b2_next;
            ax1_reg  <= DW'(iax1);
            ay1_reg  <= DW'(iay1);
            ax2_reg  <= DW'(iax2);
            ay2_reg  <= DW'(iay2);
            bx1_reg  <= DW'(ibx1);
            by1_reg  <= DW'(iby1);
            bx2_reg  <= DW'(ibx2);
            by2_reg  <= DW'(iby2);
            lo_reg   <= (EW'(iax1) < ibx1) ? DW'(ibx1) : DW'(iax1);
            hi_reg   <= (EW'(iax2) < ibx2) ? DW'(iax2) : DW'(ibx2);
            amin_reg <= (iay1 < iay2) ? DW'(iay1) : DW'(iay2);
            amax_reg <= (iay1 < iay2) ? DW'(iay2) : DW'(iay1);
            bmin_reg <= (iby1 < iby2) ? DW'(iby1) : DW'(iby2);
            bmax_reg <= (iby1 < iby2) ? DW'(iby2) : DW'(iby1);
            f1_reg.rej   <= irej;
            f1_reg.vert  <= (b_next == '0) || (b2_next == '0);
            f1_reg.aflat <= (iay1 == iay2);
            f1_reg.bflat <= (iby1 == iby2);
        end
    end

    // Stage 2
    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg   <= a_reg * b2_reg;
            p2_reg   <= a2_reg * b_reg;
            p3_reg   <= ay1_reg * ax2_reg;
            p4_reg   <= ax1_reg * ay2_reg;
            p5_reg   <= by1_reg * bx2_reg;
            p6_reg   <= bx1_reg * by2_reg;
            a_2_reg  <= a_reg;
            b_2_reg  <= b_reg;
            a2_2_reg <= a2_reg;
            b2_2_reg <= b2_reg;
            bnd2_reg[0] <= lo_reg;
            bnd2_reg[1] <= hi_reg;
            bnd2_reg[2] <= amin_reg;
            bnd2_reg[3] <= amax_reg;
            bnd2_reg[4] <= bmin_reg;
            bnd2_reg[5] <= bmax_reg;
            f2_reg   <= f1_reg;
        end
    end

    // Stage 3
    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg  <= KW'(p1_reg) - KW'(p2_reg);
            c_reg    <= KW'(p3_reg) - KW'(p4_reg);
            c2_reg   <= KW'(p5_reg) - KW'(p6_reg);
            a_3_reg  <= a_2_reg;
            b_3_reg  <= b_2_reg;
            a2_3_reg <= a2_2_reg;
            b2_3_reg <= b2_2_reg;
            bnd3_reg <= bnd2_reg;
            f3_reg   <= f2_reg;
        end
    end

    // Operands of the wide products
    always_comb begin
        mul_a[0] = c2_reg;  mul_b[0] = b_3_reg;
        mul_a[1] = c_reg;   mul_b[1] = b2_3_reg;
        mul_a[2] = c_reg;   mul_b[2] = a2_3_reg;
        mul_a[3] = c2_reg;  mul_b[3] = a_3_reg;
        for (int i = 0; i < 6; i++) begin
            mul_a[4 + i] = det_reg;
            mul_b[4 + i] = bnd3_reg[i];
        end
    end

    for (genvar g = 0; g < NMUL; g++) begin : g_mul
        sct_mul #(.AW(KW), .BW(DW)) u_mul (
            .aclk (aclk),
            .en   (en),
            .a    (mul_a[g]),
            .b    (mul_b[g]),
            .prod (mul_p[g])
        );
    end

    // Carry flags alongside the wide products
    always_ff @(posedge aclk) begin
        if (en) begin
            f4_reg      <= f3_reg;
            d4_reg.zero <= (det_reg == '0);
            d4_reg.neg  <= det_reg[KW-1];
            f5_reg      <= f4_reg;
            d5_reg      <= d4_reg;
        end
    end

    // Stage 6
    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg <= NW'(mul_p[0]) - NW'(mul_p[1]);
            ny_reg <= NW'(mul_p[2]) - NW'(mul_p[3]);
            for (int i = 0; i < 6; i++) begin
                bp_reg[i] <= NW'(mul_p[4 + i]);
            end
            f6_reg <= f5_reg;
            d6_reg <= d5_reg;
        end
    end

    // Range tests; bounds flip when the determinant is negative
    always_comb begin
        if (d6_reg.neg) begin
            in_x  = (nx_reg <= bp_reg[0]) && (nx_reg >= bp_reg[1]);
            in_ya = (ny_reg <= bp_reg[2]) && (ny_reg >= bp_reg[3]);
            in_yb = (ny_reg <= bp_reg[4]) && (ny_reg >= bp_reg[5]);
        end else begin
            in_x  = (nx_reg >= bp_reg[0]) && (nx_reg <= bp_reg[1]);
            in_ya = (ny_reg >= bp_reg[2]) && (ny_reg <= bp_reg[3]);
            in_yb = (ny_reg >= bp_reg[4]) && (ny_reg <= bp_reg[5]);
        end
        priority if (f6_reg.rej) begin
            verdict_next = VERDICT_APART;
        end else if (d6_reg.zero) begin
            verdict_next = VERDICT_PARALLEL;
        end else if (!in_x) begin
            verdict_next = VERDICT_OUTSIDE;
        end else if (f6_reg.vert && ((!f6_reg.aflat && !in_ya) || (!f6_reg.bflat && !in_yb)))
        begin
            verdict_next = VERDICT_OUTSIDE;
        end else begin
            verdict_next = VERDICT_CROSS;
        end
    end

    // Stage 7: hold the result until taken
    always_ff @(posedge aclk) begin
        if (en) begin
            verdict_reg <= verdict_next;
        end
    end

    assign out_valid   = v7_reg;
    assign out_verdict = verdict_reg;
    assign out_crosses = (verdict_reg == VERDICT_CROSS);

endmodule

// ===== rtl/segment_crossing_test.sv =====
// Segment crossing test. Each input transfer carries two segments and a
// translation for the second; one result transfer per input reports whether
// the segments cross and why not (extents apart, parallel, or crossing
// point outside a range). The block takes one transfer per cycle while the
// queue is not full. The front orders endpoints, applies the shift and
// checks extents in the accepting cycle, a 4-entry queue holds classified
// items, and the back runs a 7-stage pipeline whose depth is set by the wide
// numerator products, built as two-step split multipliers. A stall on the
// output freezes the back; the front keeps accepting until the queue fills.
module segment_crossing_test #(
    parameter int COORD_WIDTH = sct_pkg::COORD_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // a_x1, a_y1, a_x2, a_y2, b_x1, b_y1, b_x2, b_y2, shift_x, shift_y
    input  logic [((sct_pkg::NUM_COORDS*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // crosses, verdict
    output logic [7:0] m_tdata
);
    import sct_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int IW = 8 * W + 5;

    logic [IW-1:0] front_item;
    logic [IW-1:0] queue_item;
    logic          queue_full;
    logic          queue_nonempty;
    logic          back_pop;
    logic          crosses;
    logic [1:0]    verdict;

    sct_front #(.W(W)) u_front (
        .in_data (s_tdata[NUM_COORDS*W-1:0]),
        .item    (front_item)
    );

    sct_fifo #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_data (front_item),
        .full      (queue_full),
        .pop       (back_pop),
        .nonempty  (queue_nonempty),
        .pop_data  (queue_item)
    );

    sct_back #(.W(W)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (queue_nonempty),
        .in_item     (queue_item),
        .in_pop      (back_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_crosses (crosses),
        .out_verdict (verdict)
    );

    assign s_tready = !queue_full;
    assign m_tdata  = {5'b0, verdict, crosses};

    // Crossing flag agrees with the result code
    a_cross_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == VERDICT_CROSS)))
        else $error("crossing flag disagrees with verdict");

    // Queue is empty after reset, so input is ready
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // No result right after reset
    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

// ===== sim/segment_crossing_test_test.sv =====
module segment_crossing_test_test;
    import sct_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int DW = ((NUM_COORDS * CW + 7) / 8) * 8;
    localparam int STALL_LIMIT = 5000;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic     crosses;
        verdict_t verdict;
    } crossing_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [7:0]    m_tdata;

    crossing_t expected_q[$];
    int        mismatches = 0;
    int        quiet_cycles = 0;
    bit        idling = 1'b1;
    int        hold_cycles = 0;
    int        ready_wait = 0;

    segment_crossing_test dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Sign-extend one coordinate field of the input transfer
    function automatic wide_t coord_at(logic [DW-1:0] d, int idx);
        logic [CW-1:0] raw;
        raw = d[idx*CW +: CW];
        return wide_t'($signed(raw));
    endfunction

    // lo <= n/d <= hi for positive d
    function automatic bit in_range(wide_t n, wide_t d, wide_t lo, wide_t hi);
        return !(n < lo * d) && !(hi * d < n);
    endfunction

    // Work out the crossing verdict for one pair of segments
    function automatic crossing_t predict_crossing(logic [DW-1:0] d);
        wide_t ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, sx, sy, t;
        wide_t amin, amax, bmin, bmax, ea, eb, ea2, eb2, det, c1, c2, nx, ny;
        verdict_t v;
        crossing_t r;
        ax1 = coord_at(d, 0); ay1 = coord_at(d, 1);
        ax2 = coord_at(d, 2); ay2 = coord_at(d, 3);
        bx1 = coord_at(d, 4); by1 = coord_at(d, 5);
        bx2 = coord_at(d, 6); by2 = coord_at(d, 7);
        sx = coord_at(d, 8); sy = coord_at(d, 9);
        v = VERDICT_CROSS;
        // order endpoints by x
        if (ax2 < ax1) begin
            t = ax1; ax1 = ax2; ax2 = t;
            t = ay1; ay1 = ay2; ay2 = t;
        end
        if (bx2 < bx1) begin
            t = bx1; bx1 = bx2; bx2 = t;
            t = by1; by1 = by2; by2 = t;
        end
        bx1 = bx1 + sx; bx2 = bx2 + sx;
        by1 = by1 + sy; by2 = by2 + sy;
        amin = (ay2 < ay1) ? ay2 : ay1; amax = (ay1 < ay2) ? ay2 : ay1;
        bmin = (by2 < by1) ? by2 : by1; bmax = (by1 < by2) ? by2 : by1;
        if (ax2 < bx1 || bx2 < ax1 || bmax < amin || amax < bmin) begin
            v = VERDICT_APART;
        end else begin
            ea = ay2 - ay1; eb = ax1 - ax2;
            ea2 = by2 - by1; eb2 = bx1 - bx2;
            det = ea * eb2 - ea2 * eb;
            if (det == 0) begin
                v = VERDICT_PARALLEL;
            end else begin
                c1 = ay1 * ax2 - ax1 * ay2;
                c2 = by1 * bx2 - bx1 * by2;
                nx = c2 * eb - c1 * eb2;
                ny = c1 * ea2 - c2 * ea;
                if (det < 0) begin
                    det = -det; nx = -nx; ny = -ny;
                end
                if (!in_range(nx, det, (ax1 > bx1) ? ax1 : bx1,
                              (ax2 < bx2) ? ax2 : bx2)) begin
                    v = VERDICT_OUTSIDE;
                end else if (eb == 0 || eb2 == 0) begin
                    if (ay1 != ay2 && !in_range(ny, det, amin, amax))
                        v = VERDICT_OUTSIDE;
                    if (by1 != by2 && !in_range(ny, det, bmin, bmax))
                        v = VERDICT_OUTSIDE;
                end
            end
        end
        r.crosses = (v == VERDICT_CROSS);
        r.verdict = v;
        return r;
    endfunction

    // Pack ten coordinates into one transfer, first in the low bits
    function automatic logic [DW-1:0] pack_pair(int c[10]);
        logic [DW-1:0] d;
        d = '0;
        for (int i = 0; i < NUM_COORDS; i++) d[i*CW +: CW] = c[i][CW-1:0];
        return d;
    endfunction

    // Offer one transfer, after a random gap while idling; record the verdict on accept
    task automatic send_pair(logic [DW-1:0] d);
        int gap;
        gap = idling ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_q.push_back(predict_crossing(d));
        @(negedge aclk);
    endtask

    task automatic send_coords(int a0, int a1, int a2, int a3, int b0, int b1,
                               int b2, int b3, int s0, int s1);
        int c[10];
        c = '{a0, a1, a2, a3, b0, b1, b2, b3, s0, s1};
        send_pair(pack_pair(c));
    endtask

    // Random coordinate: full range, or a small window near the origin
    function automatic int rand_coord(bit near);
        if (near) return int'($urandom_range(0, 1023)) - 512;
        return int'($urandom);
    endfunction

    // Random pair: mostly near the origin so most items pass the extent test
    function automatic logic [DW-1:0] rand_pair();
        int c[10];
        bit near;
        int kind;
        near = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < NUM_COORDS; i++) c[i] = rand_coord(near);
        if (near) begin
            c[8] = int'($urandom_range(0, 63)) - 32;
            c[9] = int'($urandom_range(0, 63)) - 32;
            kind = $urandom_range(0, 7);
            case (kind)
                0: begin c[2] = c[0]; end
                1: begin c[7] = c[5]; c[6] = c[4]; end
                2: begin c[3] = c[1]; c[6] = c[4]; end
                3: begin c[4] = c[0]; c[5] = c[1]; end
                4: begin c[6] = c[4] + (c[2] - c[0]); c[7] = c[5] + (c[3] - c[1]); end
                default: ;
            endcase
        end else begin
            // raw bits above the field width must be ignored: keep full randoms
        end
        return pack_pair(c);
    endfunction

    task automatic test_extremes();
        int mx, mn;
        mx = 32'sh7fffff;
        mn = -32'sh800000;
        send_coords(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx);
        send_coords(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn);
        send_coords(mn, mn, mx, mx, mn, mx, mx, mn, 0, 0);
        send_coords(mn, mx, mx, mn, mn, mn, mx, mx, 0, 0);
        send_coords(mx, mn, mn, mx, mx, mx, mn, mn, mn, mx);
        send_coords(0, 0, mx, mx, mx, 0, 0, mx, mx, mn);
        send_coords(mn, 0, mx, 0, 0, mn, 0, mx, 0, 0);
        send_coords(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
    endtask

    task automatic test_special_cases();
        // plain crossing
        send_coords(0, 0, 256, 256, 0, 256, 256, 0, 0, 0);
        // reversed endpoints on both segments
        send_coords(256, 256, 0, 0, 256, 0, 0, 256, 0, 0);
        // extents apart in x and in y
        send_coords(0, 0, 10, 10, 20, 0, 30, 10, 0, 0);
        send_coords(0, 0, 10, 10, 0, 20, 10, 30, 0, 0);
        // shift moves b onto a and away from it
        send_coords(0, 0, 256, 256, 1000, 256, 1256, 0, -1000, 0);
        send_coords(0, 0, 256, 256, 0, 256, 256, 0, 0, 5000);
        // parallel and collinear
        send_coords(0, 0, 100, 100, 0, 10, 100, 110, 0, 0);
        send_coords(0, 0, 100, 100, 50, 50, 150, 150, 0, 0);
        // degenerate segment on a crossing line
        send_coords(50, 50, 50, 50, 0, 0, 100, 100, 0, 0);
        // touching ends
        send_coords(0, 0, 100, 100, 100, 100, 200, 0, 0, 0);
        // crossing x outside one range
        send_coords(0, 0, 100, 10, 90, 0, 200, 100, 0, 0);
        // vertical against horizontal, plain and shifted; short vertical that misses a slope
        send_coords(50, 0, 50, 100, 0, 50, 100, 50, 0, 0);
        send_coords(50, 0, 50, 100, 0, 150, 100, 150, 0, -100);
        send_coords(50, 0, 50, 40, 0, 0, 100, 100, 0, 0);
        // vertical against sloped segment
        send_coords(50, 0, 50, 100, 0, 0, 100, 100, 0, 0);
        send_coords(50, 60, 50, 100, 0, 0, 100, 100, 0, 0);
        // shifted sums past the field range
        send_coords(32'sh7fff00, 0, 32'sh7fffff, 256, 32'sh7fff00, 256,
                    32'sh7fffff, 0, 32'sh7fffff, 0);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 300 == 0) idling = ~idling;
            send_pair(rand_pair());
        end
        idling = 1'b1;
    endtask

    // Hold the result side off long enough for the block to fill and stall
    task automatic test_backpressure();
        hold_cycles = 200;
        for (int i = 0; i < 40; i++) send_pair(rand_pair());
    endtask

    // Drive result-side ready: long hold-off first, then per-transfer waits
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (ready_wait > 0) begin
            m_tready <= 1'b0;
            ready_wait <= ready_wait - 1;
        end else begin
            m_tready <= aresetn;
        end
    end

    // Check each result transfer against the oldest expectation
    always @(posedge aclk) begin
        crossing_t exp_r;
        if (aresetn && (s_tvalid && s_tready || m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            ready_wait <= idling ? $urandom_range(0, 3) : 0;
            if (expected_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result transfer: crosses=%0d verdict=%0d",
                             m_tdata[0], m_tdata[2:1]);
            end else begin
                exp_r = expected_q.pop_front();
                if (m_tdata[0] !== exp_r.crosses || m_tdata[2:1] !== exp_r.verdict) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected crosses=%0d verdict=%0d, got %0d %0d",
                                 exp_r.crosses, exp_r.verdict, m_tdata[0], m_tdata[2:1]);
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_extremes();
        test_special_cases();
        test_backpressure();
        test_random(1500);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sct_pkg.sv
rtl/sct_fifo.sv
rtl/sct_front.sv
rtl/sct_mul.sv
rtl/sct_back.sv
rtl/segment_crossing_test.sv
sim/segment_crossing_test_test.sv
